// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies consequent
`define ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/vpsc_pkg.sv =====
// Shared types, constants and codes for the voice state classifier.
// No dependencies; imported by every module of the block.
`default_nettype none
package vpsc_pkg;

    localparam int MAX_CONNECTIONS = 64;
    localparam int MAX_FRAMES      = 16;
    localparam int CONN_W          = 64;
    localparam int FRAME_W         = 4;
    localparam int CID_W           = 6;
    localparam int CFG_W           = 5;
    localparam int STATUS_W        = 3;
    localparam int LANES           = 4;
    localparam int LANE_W          = CONN_W / LANES;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 328;

    localparam logic [CONN_W-1:0] CONN_MASK =
        (MAX_CONNECTIONS >= CONN_W) ? {CONN_W{1'b1}}
                                    : ((CONN_W'(1) << MAX_CONNECTIONS) - CONN_W'(1));

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] FRAMES_MAX   = CFG_W'(MAX_FRAMES);

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_SILENCE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK               = 3'd0,
        ST_BAD_FRAME        = 3'd1,
        ST_ALREADY_SILENT   = 3'd2,
        ST_NOT_EXPECTED     = 3'd3,
        ST_REACT_NOT_SILENT = 3'd4
    } t_status;

    typedef struct packed {
        logic [LANE_W-1:0] fresh;
        logic [LANE_W-1:0] react;
        logic [LANE_W-1:0] persist;
        logic [LANE_W-1:0] unpersist;
        logic [LANE_W-1:0] silenced;
    } t_lane_masks;

    typedef struct packed {
        logic [LANE_W-1:0] expected;
        logic [LANE_W-1:0] seen;
        logic [LANE_W-1:0] known;
        logic [LANE_W-1:0] silent;
        logic [LANE_W-1:0] sil_expected;
        logic [LANE_W-1:0] sil_silent;
    } t_lane_next;

    typedef struct packed {
        logic react_not_silent;
        logic hit_silent;
        logic hit_expected;
    } t_lane_flags;

    typedef struct packed {
        logic upd;
        logic sil;
    } t_commit;

endpackage
`default_nettype wire

// ===== rtl/voip_persistent_state_classifier_top.sv =====
// Top level of the voice state classifier: frame-slot state, lanes, merge, output register.
// Depends on vpsc_pkg, vpsc_lane and vpsc_merge.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: frame, active_mask, conn_id; tuser: opcode
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: new, reactivated, persistent,
//           |     |                              |        unpersistent, silenced, status
//  cfg      | in  | i_cfg_valid/o_cfg_ready      | i_cfg_data: frames_in_use
//
// One item per cycle while the output is not stalled; the result shows in the cycle after the item is accepted.
// The frame-slot read-modify-write completes in the accept cycle, so items
// for the same slot may follow each other with no gap.
// Reset clears all slot maps, the known and silent maps and sets frames_in_use to 16.
// A stalled result holds in the output register; input is taken while the
// register is empty or being drained.
`default_nettype none
module voip_persistent_state_classifier_top import vpsc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [3:0] frame, [67:4] active_mask, [73:68] conn_id, [79:74] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [63:0] new_mask, [127:64] reactivated_mask, [191:128] persistent_mask,
    // [255:192] unpersistent_mask, [319:256] silenced_mask, [322:320] status, [327:323] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    logic [CONN_W-1:0]  r_expected [MAX_FRAMES];
    logic [CONN_W-1:0]  r_seen     [MAX_FRAMES];
    logic [CONN_W-1:0]  r_known;
    logic [CONN_W-1:0]  r_silent;
    logic [CFG_W-1:0]   r_frames;
    logic               r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [FRAME_W-1:0] frame;
    logic [CONN_W-1:0]  active;
    logic [CID_W-1:0]   conn_id;
    t_opcode            opcode;
    logic [CONN_W-1:0]  conn_bit;
    logic [CONN_W-1:0]  cur_expected;
    logic [CONN_W-1:0]  cur_seen;
    logic [CFG_W-1:0]   frame_lim;
    logic               frame_ok;
    logic               cid_ok;
    logic               accept;

    t_lane_masks        lane_masks [LANES];
    t_lane_next         lane_next  [LANES];
    t_lane_flags        lane_flags [LANES];
    t_status            status;
    t_commit            commit;

    logic [CONN_W-1:0]  m_fresh, m_react, m_persist, m_unpersist, m_silenced;
    logic [CONN_W-1:0]  n_expected, n_seen, n_known, n_silent;
    logic [CONN_W-1:0]  n_sil_expected, n_sil_silent;
    logic [OUT_DATA_W-1:0] n_odata;

    assign frame   = s_axis_tdata[FRAME_W-1:0];
    assign active  = s_axis_tdata[FRAME_W +: CONN_W] & CONN_MASK;
    assign conn_id = s_axis_tdata[FRAME_W+CONN_W +: CID_W];
    assign opcode  = t_opcode'(s_axis_tuser);

    assign conn_bit     = CONN_W'(1) << conn_id;
    assign cur_expected = r_expected[frame];
    assign cur_seen     = r_seen[frame];

    assign frame_lim = (r_frames > FRAMES_MAX) ? FRAMES_MAX : r_frames;
    assign frame_ok  = {1'b0, frame} < frame_lim;
    assign cid_ok    = {1'b0, conn_id} < (CID_W+1)'(MAX_CONNECTIONS);

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vpsc_lane u_lane (
            .i_active   (active[g*LANE_W +: LANE_W]),
            .i_expected (cur_expected[g*LANE_W +: LANE_W]),
            .i_seen     (cur_seen[g*LANE_W +: LANE_W]),
            .i_known    (r_known[g*LANE_W +: LANE_W]),
            .i_silent   (r_silent[g*LANE_W +: LANE_W]),
            .i_conn_bit (conn_bit[g*LANE_W +: LANE_W]),
            .o_masks    (lane_masks[g]),
            .o_next     (lane_next[g]),
            .o_flags    (lane_flags[g])
        );
    end

    vpsc_merge u_merge (
        .i_flags    (lane_flags),
        .i_opcode   (opcode),
        .i_frame_ok (frame_ok),
        .i_cid_ok   (cid_ok),
        .o_status   (status),
        .o_commit   (commit)
    );

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            m_fresh[l*LANE_W +: LANE_W]        = lane_masks[l].fresh;
            m_react[l*LANE_W +: LANE_W]        = lane_masks[l].react;
            m_persist[l*LANE_W +: LANE_W]      = lane_masks[l].persist;
            m_unpersist[l*LANE_W +: LANE_W]    = lane_masks[l].unpersist;
            m_silenced[l*LANE_W +: LANE_W]     = lane_masks[l].silenced;
            n_expected[l*LANE_W +: LANE_W]     = lane_next[l].expected;
            n_seen[l*LANE_W +: LANE_W]         = lane_next[l].seen;
            n_known[l*LANE_W +: LANE_W]        = lane_next[l].known;
            n_silent[l*LANE_W +: LANE_W]       = lane_next[l].silent;
            n_sil_expected[l*LANE_W +: LANE_W] = lane_next[l].sil_expected;
            n_sil_silent[l*LANE_W +: LANE_W]   = lane_next[l].sil_silent;
        end

        n_odata = '0;
        n_odata[OUT_DATA_W-1 -: (OUT_DATA_W - 5*CONN_W - STATUS_W)] = '0;
        n_odata[5*CONN_W +: STATUS_W] = status;
        if (commit.upd) begin
            n_odata[0*CONN_W +: CONN_W] = m_fresh;
            n_odata[1*CONN_W +: CONN_W] = m_react;
            n_odata[2*CONN_W +: CONN_W] = m_persist;
            n_odata[3*CONN_W +: CONN_W] = m_unpersist;
            n_odata[4*CONN_W +: CONN_W] = m_silenced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < MAX_FRAMES; f++) begin
                r_expected[f] <= '0;
                r_seen[f]     <= '0;
            end
            r_known  <= '0;
            r_silent <= '0;
            r_frames <= FRAMES_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_frames <= i_cfg_data;
            end
            if (accept && commit.upd) begin
                r_expected[frame] <= n_expected;
                r_seen[frame]     <= n_seen;
                r_known           <= n_known;
                r_silent          <= n_silent;
            end
            if (accept && commit.sil) begin
                r_expected[frame] <= n_sil_expected;
                r_silent          <= n_sil_silent;
            end
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odata <= n_odata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
`default_nettype wire

// ===== rtl/vpsc_lane.sv =====
// One lane: per-connection set logic on a slice of the connection bitmaps.
// Depends on vpsc_pkg.
`default_nettype none
module vpsc_lane import vpsc_pkg::*; (
    input  wire logic [LANE_W-1:0] i_active,
    input  wire logic [LANE_W-1:0] i_expected,
    input  wire logic [LANE_W-1:0] i_seen,
    input  wire logic [LANE_W-1:0] i_known,
    input  wire logic [LANE_W-1:0] i_silent,
    input  wire logic [LANE_W-1:0] i_conn_bit,
    output t_lane_masks            o_masks,
    output t_lane_next             o_next,
    output t_lane_flags            o_flags
);

    logic [LANE_W-1:0] unknown;
    logic [LANE_W-1:0] fresh;
    logic [LANE_W-1:0] first;
    logic [LANE_W-1:0] unexp;
    logic [LANE_W-1:0] react;
    logic [LANE_W-1:0] silent_kept;
    logic [LANE_W-1:0] noise;
    logic [LANE_W-1:0] persist;
    logic [LANE_W-1:0] silenced;

    always_comb begin
        persist     = i_expected & i_active;
        silenced    = i_expected & ~i_active;
        unknown     = i_active & ~i_known;
        fresh       = unknown & i_seen;
        first       = unknown & ~i_seen;
        unexp       = i_active & i_known & ~i_expected;
        react       = unexp & i_seen;
        silent_kept = i_silent & ~react;
        noise       = unexp & ~i_seen & silent_kept;

        o_masks.fresh     = fresh;
        o_masks.react     = react;
        o_masks.persist   = persist;
        o_masks.unpersist = first | noise;
        o_masks.silenced  = silenced;

        o_next.expected     = persist | fresh | react;
        o_next.seen         = first | noise;
        o_next.known        = i_known | fresh;
        o_next.silent       = silent_kept | silenced;
        o_next.sil_expected = i_expected & ~i_conn_bit;
        o_next.sil_silent   = i_silent | i_conn_bit;

        o_flags.react_not_silent = |(react & ~i_silent);
        o_flags.hit_silent       = |(i_silent & i_conn_bit);
        o_flags.hit_expected     = |(i_expected & i_conn_bit);
    end

endmodule
`default_nettype wire

// ===== rtl/vpsc_merge.sv =====
// Merge stage: combines lane flags into the item status and commit decision.
// Depends on vpsc_pkg.
`default_nettype none
module vpsc_merge import vpsc_pkg::*; (
    input  wire t_lane_flags  i_flags [LANES],
    input  wire t_opcode      i_opcode,
    input  wire logic         i_frame_ok,
    input  wire logic         i_cid_ok,
    output t_status           o_status,
    output t_commit           o_commit
);

    logic any_rns;
    logic any_silent;
    logic any_expected;

    always_comb begin
        any_rns      = 1'b0;
        any_silent   = 1'b0;
        any_expected = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            any_rns      = any_rns | i_flags[l].react_not_silent;
            any_silent   = any_silent | i_flags[l].hit_silent;
            any_expected = any_expected | i_flags[l].hit_expected;
        end

        o_status   = ST_OK;
        o_commit   = '0;
        if (!i_frame_ok) begin
            o_status = ST_BAD_FRAME;
        end else begin
            case (i_opcode)
                OP_SILENCE: begin
                    if (any_silent) begin
                        o_status = ST_ALREADY_SILENT;
                    end else if (!i_cid_ok || !any_expected) begin
                        o_status = ST_NOT_EXPECTED;
                    end else begin
                        o_commit.sil = 1'b1;
                    end
                end
                OP_UPDATE: begin
                    if (any_rns) begin
                        o_status = ST_REACT_NOT_SILENT;
                    end
                    o_commit.upd = 1'b1;
                end
                default: begin
                    o_status = ST_BAD_FRAME;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vpsc_checker.sv =====
// Port-level checker for the voice state classifier, bound to the top level.
// Depends on vpsc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module vpsc_checker import vpsc_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [CONN_W-1:0]   o_persist;
    logic [CONN_W-1:0]   o_silenced;
    logic [STATUS_W-1:0] o_status;
    logic                masks_zero;
    logic                status_rejects;

    assign o_persist      = m_axis_tdata[2*CONN_W +: CONN_W];
    assign o_silenced     = m_axis_tdata[4*CONN_W +: CONN_W];
    assign o_status       = m_axis_tdata[5*CONN_W +: STATUS_W];
    assign masks_zero     = m_axis_tdata[5*CONN_W-1:0] == '0;
    assign status_rejects = (o_status == ST_BAD_FRAME) || (o_status == ST_ALREADY_SILENT)
                         || (o_status == ST_NOT_EXPECTED);

    `ASSERT_NEXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid)
    `ASSERT_NEXT(a_stall_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_SAME(a_disjoint, i_clk, !i_rst_n, m_axis_tvalid, (o_persist & o_silenced) == '0)
    `ASSERT_SAME(a_reject_zero, i_clk, !i_rst_n, m_axis_tvalid && status_rejects, masks_zero)
    `ASSERT_SAME(a_drain_ready, i_clk, !i_rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)

endmodule

bind voip_persistent_state_classifier_top vpsc_checker u_vpsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
